@@ rtl/ogt_pkg.sv @@
// ----------------------------------------------------------------------------
// ogt_pkg: shared types and constants for the orbit ground track unit
// Datapath widths, CORDIC gain constants, arctangent table and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ogt_pkg;

    // coordinate width: signed Q2.30 with headroom for CORDIC growth
    localparam int DW = 36;
    // rotation angle accumulator width
    localparam int ZW = 34;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [DW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic [31:0] GAIN_Q31 = 32'd1304065748;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_ORBIT_RATE = 2'd0;
    localparam reg_index_t REG_EARTH_RATE = 2'd1;
    localparam reg_index_t REG_COS_INCL   = 2'd2;
    localparam reg_index_t REG_SIN_INCL   = 2'd3;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

`default_nettype wire

@@ rtl/ogt_phase.sv @@
// ----------------------------------------------------------------------------
// ogt_phase: orbit and earth phase from a time stamp
// Two-stage multiply: split 32x40 products, then sum modulo one turn.
// ----------------------------------------------------------------------------
`default_nettype none

module ogt_phase #(
    parameter int ANGLE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] time_s,
    input  logic [39:0] orbit_rate,
    input  logic [39:0] earth_rate,
    output logic        out_valid,
    output logic [31:0] orbit_phase,
    output logic [31:0] earth_phase
);
    import ogt_pkg::*;

    // keep the top ANGLE_BITS of the 32-bit angle
    localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic        v1_reg;
    logic [47:0] orb_lo_reg, ear_lo_reg;
    logic [15:0] orb_hi_reg, ear_hi_reg;
    logic [63:0] orb_lo_next, ear_lo_next;
    logic [39:0] orb_hi_next, ear_hi_next;
    logic [47:0] orb_frac, ear_frac;

    assign orb_lo_next = time_s * orbit_rate[31:0];
    assign ear_lo_next = time_s * earth_rate[31:0];
    assign orb_hi_next = time_s * orbit_rate[39:32];
    assign ear_hi_next = time_s * earth_rate[39:32];

    assign orb_frac = orb_lo_reg + {orb_hi_reg, 32'd0};
    assign ear_frac = ear_lo_reg + {ear_hi_reg, 32'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        orb_lo_reg  <= orb_lo_next[47:0];
        ear_lo_reg  <= ear_lo_next[47:0];
        orb_hi_reg  <= orb_hi_next[15:0];
        ear_hi_reg  <= ear_hi_next[15:0];
        orbit_phase <= orb_frac[47:16] & PH_MASK;
        earth_phase <= ear_frac[47:16] & PH_MASK;
    end

    a_phase_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((orbit_phase & ~PH_MASK) == 32'd0 && (earth_phase & ~PH_MASK) == 32'd0))
        else $error("phase carries bits below the angle resolution");

endmodule

`default_nettype wire

@@ rtl/ogt_cordic.sv @@
// ----------------------------------------------------------------------------
// ogt_cordic: pipelined CORDIC, rotation or vectoring
// One register stage for quadrant prep, one per iteration, one for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ogt_cordic #(
    parameter int STAGES = 24,
    parameter bit VECTOR = 1'b0,
    parameter int SW     = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [ogt_pkg::DW-1:0] in_x,
    input  logic signed [ogt_pkg::DW-1:0] in_y,
    input  logic [31:0]                  in_z,
    input  logic [SW-1:0]                in_side,
    output logic                         out_valid,
    output logic signed [ogt_pkg::DW-1:0] out_x,
    output logic signed [ogt_pkg::DW-1:0] out_y,
    output logic [31:0]                  out_z,
    output logic [SW-1:0]                out_side
);
    import ogt_pkg::*;

    localparam int LAT = STAGES + 2;

    logic signed [DW-1:0] x_reg [0:STAGES];
    logic signed [DW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    logic [SW-1:0]        side_reg [0:STAGES];
    logic [STAGES:0]      v_reg;
    logic [STAGES:0]      flip_reg;

    logic                 flip0;
    logic signed [DW-1:0] x0, y0;
    logic signed [ZW-1:0] z0;
    logic [31:0]          a_rot, a_chk;

    // fold the start into the right half plane
    always_comb
    begin
        a_chk = in_z + QUARTER_TURN;
        a_rot = in_z;
        if (VECTOR)
        begin
            flip0 = in_x[DW-1];
            x0    = flip0 ? -in_x : in_x;
            y0    = flip0 ? -in_y : in_y;
            z0    = flip0 ? {{(ZW-32){1'b0}}, HALF_TURN} : '0;
        end
        else
        begin
            flip0 = a_chk[31];
            if (flip0)
                a_rot = in_z + HALF_TURN;
            x0 = GAIN_Q30;
            y0 = '0;
            z0 = {{(ZW-32){a_rot[31]}}, a_rot};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0;
        y_reg[0]    <= y0;
        z_reg[0]    <= z0;
        flip_reg[0] <= flip0;
        side_reg[0] <= in_side;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] ANG = {{(ZW-32){1'b0}}, ATAN_TAB[i]};
        logic signed [DW-1:0] dx, dy;
        logic                 dir, add_x;

        assign dx    = y_reg[i] >>> i;
        assign dy    = x_reg[i] >>> i;
        assign dir   = VECTOR ? !y_reg[i][DW-1] : !z_reg[i][ZW-1];
        assign add_x = VECTOR ? dir : !dir;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]    <= add_x ? x_reg[i] + dx : x_reg[i] - dx;
            y_reg[i+1]    <= add_x ? y_reg[i] - dy : y_reg[i] + dy;
            z_reg[i+1]    <= add_x ? z_reg[i] + ANG : z_reg[i] - ANG;
            flip_reg[i+1] <= flip_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= v_reg[STAGES];
    end

    // undo the half-turn fold of a rotation
    always_ff @(posedge clk)
    begin
        out_x    <= (!VECTOR && flip_reg[STAGES]) ? -x_reg[STAGES] : x_reg[STAGES];
        out_y    <= (!VECTOR && flip_reg[STAGES]) ? -y_reg[STAGES] : y_reg[STAGES];
        out_z    <= z_reg[STAGES][31:0];
        out_side <= side_reg[STAGES];
    end

    a_valid_latency: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(in_valid, LAT))
        else $error("CORDIC result without a request LAT cycles earlier");

endmodule

`default_nettype wire

@@ rtl/orbit_ground_track_unit.sv @@
// ----------------------------------------------------------------------------
// orbit_ground_track_unit: sub-satellite latitude and longitude
// Phase multiply, CORDIC rotation, inclination tilt and two vectoring passes.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy is always low.
// Each request yields one result on latitude and longitude, marked by a
// one-cycle done strobe, in request order. The path is made of the phase
// multiplier, the three CORDIC pipelines and three registered
// multiply/round stages. Results cannot be held off. Write the rate and
// inclination registers only while no request is in flight.
`default_nettype none

module orbit_ground_track_unit #(
    parameter int ANGLE_BITS    = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [31:0]                time_s,
    input  logic                       cfg_we,
    input  ogt_pkg::reg_index_t        cfg_index,
    input  logic [39:0]                cfg_data,
    output logic                       done,
    output logic signed [23:0]         latitude,
    output logic signed [23:0]         longitude
);
    import ogt_pkg::*;

    localparam int TOTAL_LAT = 3 * CORDIC_STAGES + 11;
    localparam logic [31:0] HALF_STEP = (32'd1 << (32 - ANGLE_BITS)) >> 1;

    logic [39:0]        orbit_rate_reg, earth_rate_reg;
    logic signed [18:0] cos_incl_reg, sin_incl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbit_rate_reg <= 40'd50840955000;
            earth_rate_reg <= 40'd3265485800;
            cos_incl_reg   <= 19'sd81346;
            sin_incl_reg   <= 19'sd102774;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORBIT_RATE: orbit_rate_reg <= cfg_data;
                REG_EARTH_RATE: earth_rate_reg <= cfg_data;
                REG_COS_INCL:   cos_incl_reg   <= cfg_data[18:0];
                REG_SIN_INCL:   sin_incl_reg   <= cfg_data[18:0];
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // phase
    logic        ph_valid;
    logic [31:0] orbit_phase, earth_phase;

    ogt_phase #(.ANGLE_BITS(ANGLE_BITS)) u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .time_s      (time_s),
        .orbit_rate  (orbit_rate_reg),
        .earth_rate  (earth_rate_reg),
        .out_valid   (ph_valid),
        .orbit_phase (orbit_phase),
        .earth_phase (earth_phase)
    );

    // sine and cosine of the orbit phase
    logic                 rot_valid;
    logic signed [DW-1:0] rot_c, rot_s;
    logic [31:0]          rot_earth;

    ogt_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .SW(32)) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_x      ('0),
        .in_y      ('0),
        .in_z      (orbit_phase),
        .in_side   (earth_phase),
        .out_valid (rot_valid),
        .out_x     (rot_c),
        .out_y     (rot_s),
        .out_z     (),
        .out_side  (rot_earth)
    );

    // tilt by the inclination
    logic                    tilt_valid_reg;
    logic signed [DW-1:0]    xt_reg, yt_reg, zt_reg;
    logic [31:0]             tilt_earth_reg;
    logic signed [DW+18:0]   px, pz, px_sh, pz_sh;

    assign px    = rot_s * cos_incl_reg;
    assign pz    = rot_s * sin_incl_reg;
    assign px_sh = px >>> 17;
    assign pz_sh = pz >>> 17;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tilt_valid_reg <= 1'b0;
        else
            tilt_valid_reg <= rot_valid;
    end

    always_ff @(posedge clk)
    begin
        xt_reg         <= px_sh[DW-1:0];
        zt_reg         <= pz_sh[DW-1:0];
        yt_reg         <= rot_c;
        tilt_earth_reg <= rot_earth;
    end

    // in-plane magnitude and right ascension
    logic                 v1_valid;
    logic signed [DW-1:0] v1_mag;
    logic [31:0]          v1_ang;
    logic [DW+31:0]       v1_side;

    ogt_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SW(DW + 32)) u_vec_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tilt_valid_reg),
        .in_x      (xt_reg),
        .in_y      (yt_reg),
        .in_z      (32'd0),
        .in_side   ({zt_reg, tilt_earth_reg}),
        .out_valid (v1_valid),
        .out_x     (v1_mag),
        .out_y     (),
        .out_z     (v1_ang),
        .out_side  (v1_side)
    );

    // remove the CORDIC gain from the magnitude, add the earth phase
    logic                 gain_valid_reg;
    logic signed [DW-1:0] mc_reg, zt2_reg;
    logic [31:0]          lon_reg;
    logic [DW+31:0]       pm;

    assign pm = $unsigned(v1_mag) * GAIN_Q31;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_valid_reg <= 1'b0;
        else
            gain_valid_reg <= v1_valid;
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= pm[DW+30:31];
        zt2_reg <= v1_side[DW+31:32];
        lon_reg <= v1_ang + v1_side[31:0];
    end

    // latitude
    logic        v2_valid;
    logic [31:0] lat_ang, lon_ang;

    ogt_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .SW(32)) u_vec_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gain_valid_reg),
        .in_x      (mc_reg),
        .in_y      (zt2_reg),
        .in_z      (32'd0),
        .in_side   (lon_reg),
        .out_valid (v2_valid),
        .out_x     (),
        .out_y     (),
        .out_z     (lat_ang),
        .out_side  (lon_ang)
    );

    // round to the output resolution
    logic [31:0]                 lat_r, lon_r;
    logic signed [ANGLE_BITS-1:0] lat_v, lon_v;

    assign lat_r = lat_ang + HALF_STEP;
    assign lon_r = lon_ang + HALF_STEP;
    assign lat_v = lat_r[31:32-ANGLE_BITS];
    assign lon_v = lon_r[31:32-ANGLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v2_valid;
    end

    always_ff @(posedge clk)
    begin
        latitude  <= 24'(lat_v);
        longitude <= 24'(lon_v);
    end

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result strobe without a matching request");

endmodule

`default_nettype wire
